// ----- hdl/pppd_pkg.sv -----
// Shared types, constants and the divider step for the point projector.
// No dependencies; the two interfaces and the projector top level import this package.
package pppd_pkg;

    localparam int CoordBits   = 12;
    localparam int DotRadius   = 1;
    localparam int DotSide     = 2 * DotRadius + 1;
    localparam int DotCount    = DotSide * DotSide;
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 48;
    localparam int DivW        = 54;
    localparam int QuoW        = CoordBits + 1;

    localparam logic [23:0] GreenBgr = 24'h00FF00;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_CENTER_X  = 3'd2,
        CFG_CENTER_Y  = 3'd3,
        CFG_ROI_RECT  = 3'd4,
        CFG_PANEL     = 3'd5,
        CFG_ZOOM_GAIN = 3'd6,
        CFG_USE_COLOR = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               point_finite;
        logic [23:0]        point_rgb;
    } t_point;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic [23:0] pixel_bgr;
        logic        last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [QuoW-1:0] quo;
    } t_div;

    // One multiplier bit of floor(a*k/d), a < d: double, reduce, add a, reduce
    function automatic t_div div_step(t_div s, logic kbit,
                                      logic [DivW-1:0] a, logic [DivW-1:0] d);
        t_div o;
        o.rem = s.rem << 1;
        o.quo = s.quo << 1;
        if (o.rem >= d) begin
            o.quo = o.quo + QuoW'(1);
            o.rem = o.rem - d;
        end
        if (kbit) begin
            o.rem = o.rem + a;
            if (o.rem >= d) begin
                o.quo = o.quo + QuoW'(1);
                o.rem = o.rem - d;
            end
        end
        return o;
    endfunction

endpackage

// ----- hdl/pppd_point_if.sv -----
// Request channel carrying one camera-frame point.
// Depends on pppd_pkg for the payload type.
interface pppd_point_if;
    import pppd_pkg::*;
    logic   valid;
    logic   ready;
    t_point data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/pppd_pixel_if.sv -----
// Request channel carrying one dot pixel.
// Depends on pppd_pkg for the payload type.
interface pppd_pixel_if;
    import pppd_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/pinhole_point_projector_dots.sv -----
// Channel   Dir  Handshake          Payload
// i_pt      in   valid/ready        point_x, point_y, point_z, point_finite, point_rgb
// o_px      out  valid/ready        pixel_col, pixel_row, pixel_bgr, last_pixel
// i_cfg_*   in   write enable only  register index, 48-bit data
// Pipeline from point request to first pixel: products, bounds, 12 divider stages,
// mapping, zoom multiply, rounding, then the dot emitter.
// One pixel leaves per cycle while o_px is ready; a point yields 0..9 pixels,
// and a point with no pixel still passes through the emitter, so throughput is
// set by the single output port of the dot emitter.
// Reset is synchronous, active low: clears valid bits and emitter, loads config defaults.
// A point waiting on a stalled emitter freezes the pipeline; nothing is dropped or repeated.
// Depends on pppd_pkg, pppd_point_if and pppd_pixel_if.
module pinhole_point_projector_dots (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pppd_point_if.sink                        i_pt,
    pppd_pixel_if.source                      o_px,
    input  logic                              i_cfg_we,
    input  logic [pppd_pkg::CfgIdxBits-1:0]   i_cfg_idx,
    input  logic [pppd_pkg::CfgDataBits-1:0]  i_cfg_data
);
    import pppd_pkg::*;

    typedef struct packed {
        logic [DivW-1:0] ax;
        logic [DivW-1:0] dx;
        logic [DivW-1:0] ay;
        logic [DivW-1:0] dy;
        t_div            divx;
        t_div            divy;
        logic [23:0]     rgb;
    } t_dvs;

    // configuration
    logic [23:0] r_fx, r_fy;
    logic [19:0] r_cx, r_cy;
    logic [47:0] r_roi, r_pan;
    logic [11:0] r_zg;
    logic        r_usec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx   <= 24'd153600;
            r_fy   <= 24'd153600;
            r_cx   <= 20'd81920;
            r_cy   <= 20'd61440;
            r_roi  <= '0;
            r_pan  <= '0;
            r_zg   <= 12'd256;
            r_usec <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL_X:   r_fx   <= i_cfg_data[23:0];
                CFG_FOCAL_Y:   r_fy   <= i_cfg_data[23:0];
                CFG_CENTER_X:  r_cx   <= i_cfg_data[19:0];
                CFG_CENTER_Y:  r_cy   <= i_cfg_data[19:0];
                CFG_ROI_RECT:  r_roi  <= i_cfg_data;
                CFG_PANEL:     r_pan  <= i_cfg_data;
                CFG_ZOOM_GAIN: r_zg   <= i_cfg_data[11:0];
                CFG_USE_COLOR: r_usec <= i_cfg_data[0];
                default:       r_usec <= r_usec;
            endcase
        end
    end

    logic [CoordBits-1:0] rx, ry, rw, rh, qx, qy, qw, qh;
    logic [CoordBits-1:0] ksx, ksy;
    logic                 negx, negy;
    logic [CoordBits+1:0] c2x, c2y;

    assign rx = r_roi[CoordBits-1:0];
    assign ry = r_roi[2*CoordBits-1:CoordBits];
    assign rw = r_roi[3*CoordBits-1:2*CoordBits];
    assign rh = r_roi[4*CoordBits-1:3*CoordBits];
    assign qx = r_pan[CoordBits-1:0];
    assign qy = r_pan[2*CoordBits-1:CoordBits];
    assign qw = r_pan[3*CoordBits-1:2*CoordBits];
    assign qh = r_pan[4*CoordBits-1:3*CoordBits];

    // narrow panel flips the sign of the mapping scale
    assign negx = (qw < CoordBits'(2));
    assign negy = (qh < CoordBits'(2));
    assign ksx  = negx ? CoordBits'(2) - qw : qw - CoordBits'(2);
    assign ksy  = negy ? CoordBits'(2) - qh : qh - CoordBits'(2);
    // panel centre in half pixels
    assign c2x  = {1'b0, qx, 1'b0} + {2'b00, qw};
    assign c2y  = {1'b0, qy, 1'b0} + {2'b00, qh};

    logic en;

    // stage 1: products
    logic               r1_vld;
    logic signed [56:0] r1_fxx, r1_fyy;
    logic signed [52:0] r1_cxz, r1_cyz;
    logic signed [45:0] r1_lox, r1_hix, r1_wx, r1_loy, r1_hiy, r1_wy;
    logic [23:0]        r1_rgb;

    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_pt.valid && i_pt.data.point_finite && (i_pt.data.point_z > 32'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_fxx <= $signed({1'b0, r_fx}) * i_pt.data.point_x;
            r1_fyy <= $signed({1'b0, r_fy}) * i_pt.data.point_y;
            r1_cxz <= $signed({1'b0, r_cx}) * i_pt.data.point_z;
            r1_cyz <= $signed({1'b0, r_cy}) * i_pt.data.point_z;
            r1_lox <= $signed({1'b0, rx}) * i_pt.data.point_z;
            r1_loy <= $signed({1'b0, ry}) * i_pt.data.point_z;
            r1_hix <= $signed({2'b00, rx} + {2'b00, rw}) * i_pt.data.point_z;
            r1_hiy <= $signed({2'b00, ry} + {2'b00, rh}) * i_pt.data.point_z;
            r1_wx  <= $signed({1'b0, rw}) * i_pt.data.point_z;
            r1_wy  <= $signed({1'b0, rh}) * i_pt.data.point_z;
            r1_rgb <= i_pt.data.point_rgb;
        end
    end

    // stage 2: region test, numerators and denominators
    logic signed [57:0] nux, nuy, lox8, hix8, loy8, hiy8;
    logic               keep;

    assign nux  = 58'(r1_fxx) + 58'(r1_cxz);
    assign nuy  = 58'(r1_fyy) + 58'(r1_cyz);
    assign lox8 = 58'(r1_lox) <<< 8;
    assign hix8 = 58'(r1_hix) <<< 8;
    assign loy8 = 58'(r1_loy) <<< 8;
    assign hiy8 = 58'(r1_hiy) <<< 8;
    assign keep = (nux >= lox8) && (nux < hix8) && (nuy >= loy8) && (nuy < hiy8);

    t_dvs r_dv     [0:CoordBits];
    logic r_dv_vld [0:CoordBits];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r1_vld && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0].ax   <= DivW'(nux - lox8);
            r_dv[0].ay   <= DivW'(nuy - loy8);
            r_dv[0].dx   <= DivW'(r1_wx) << 8;
            r_dv[0].dy   <= DivW'(r1_wy) << 8;
            r_dv[0].divx <= '0;
            r_dv[0].divy <= '0;
            r_dv[0].rgb  <= r1_rgb;
        end
    end

    // divider stages: one scale bit each, most significant first
    for (genvar s = 1; s <= CoordBits; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s] <= 1'b0;
            end else if (en) begin
                r_dv_vld[s] <= r_dv_vld[s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[s].ax   <= r_dv[s-1].ax;
                r_dv[s].ay   <= r_dv[s-1].ay;
                r_dv[s].dx   <= r_dv[s-1].dx;
                r_dv[s].dy   <= r_dv[s-1].dy;
                r_dv[s].rgb  <= r_dv[s-1].rgb;
                r_dv[s].divx <= div_step(r_dv[s-1].divx, ksx[CoordBits-s],
                                         r_dv[s-1].ax, r_dv[s-1].dx);
                r_dv[s].divy <= div_step(r_dv[s-1].divy, ksy[CoordBits-s],
                                         r_dv[s-1].ay, r_dv[s-1].dy);
            end
        end
    end

    // stage: map into panel interior
    logic               r3_vld;
    logic signed [15:0] r3_col, r3_row;
    logic [23:0]        r3_rgb;
    logic signed [15:0] qqx, qqy;

    assign qqx = $signed({3'b000, r_dv[CoordBits].divx.quo});
    assign qqy = $signed({3'b000, r_dv[CoordBits].divy.quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r_dv_vld[CoordBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_col <= $signed({4'b0000, qx}) + 16'sd1 + (negx ? -qqx : qqx);
            r3_row <= $signed({4'b0000, qy}) + 16'sd1 + (negy ? -qqy : qqy);
            r3_rgb <= r_dv[CoordBits].rgb;
        end
    end

    // stage: zoom product about the centre
    logic               r4_vld;
    logic signed [31:0] r4_px, r4_py;
    logic [23:0]        r4_rgb;
    logic signed [17:0] dfx, dfy;
    logic signed [12:0] zgs;

    assign dfx = (18'(r3_col) <<< 1) - $signed({4'b0000, c2x});
    assign dfy = (18'(r3_row) <<< 1) - $signed({4'b0000, c2y});
    assign zgs = $signed({1'b0, r_zg});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_px  <= dfx * zgs;
            r4_py  <= dfy * zgs;
            r4_rgb <= r3_rgb;
        end
    end

    // stage: add centre and round half away from zero
    function automatic logic signed [23:0] round512(logic signed [31:0] v);
        logic [31:0] mag;
        logic [31:0] rr;
        mag = (v >= 32'sd0) ? v : -v;
        rr  = (mag + 32'd256) >> 9;
        return (v >= 32'sd0) ? $signed(rr[23:0]) : -$signed(rr[23:0]);
    endfunction

    logic               r5_vld;
    logic signed [23:0] r5_col, r5_row;
    logic [23:0]        r5_bgr;
    logic signed [31:0] vx, vy;

    assign vx = 32'($signed({1'b0, c2x, 8'h00})) + r4_px;
    assign vy = 32'($signed({1'b0, c2y, 8'h00})) + r4_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_col <= round512(vx);
            r5_row <= round512(vy);
            r5_bgr <= r_usec ? {r4_rgb[7:0], r4_rgb[15:8], r4_rgb[23:16]} : GreenBgr;
        end
    end

    // dot mask: which pixels lie strictly inside the panel and in range
    logic [DotCount-1:0] mask;

    always_comb begin
        logic signed [25:0] xx, yy;
        int                 j;
        mask = '0;
        j    = 0;
        for (int dy = -DotRadius; dy <= DotRadius; dy++) begin
            for (int dx = -DotRadius; dx <= DotRadius; dx++) begin
                xx = 26'(r5_col) + 26'(dx);
                yy = 26'(r5_row) + 26'(dy);
                mask[j] = (xx > $signed({14'd0, qx}))
                       && (xx < $signed({14'd0, qx}) + $signed({14'd0, qw}) - 26'sd1)
                       && (xx < 26'sd1 <<< CoordBits)
                       && (yy > $signed({14'd0, qy}))
                       && (yy < $signed({14'd0, qy}) + $signed({14'd0, qh}) - 26'sd1)
                       && (yy < 26'sd1 <<< CoordBits);
                j = j + 1;
            end
        end
    end

    // dot emitter: one pixel per cycle while o_px is ready, lowest mask bit first (row-major)
    logic [DotCount-1:0] r_em_mask;
    logic signed [23:0]  r_em_col, r_em_row;
    logic [23:0]         r_em_bgr;
    logic [DotCount-1:0] rest, sel;
    logic                hs, ek;
    logic signed [23:0]  offx, offy;

    assign rest = r_em_mask & (r_em_mask - DotCount'(1));
    assign sel  = r_em_mask & ~rest;
    assign hs   = o_px.valid && o_px.ready;
    assign ek   = (r_em_mask == '0) || (hs && (rest == '0));
    assign en   = !r5_vld || ek;

    always_comb begin
        int j;
        offx = '0;
        offy = '0;
        j    = 0;
        for (int dy = -DotRadius; dy <= DotRadius; dy++) begin
            for (int dx = -DotRadius; dx <= DotRadius; dx++) begin
                if (sel[j]) begin
                    offx = 24'(dx);
                    offy = 24'(dy);
                end
                j = j + 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_mask <= '0;
        end else if (en && r5_vld) begin
            r_em_mask <= mask;
        end else if (hs) begin
            r_em_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r5_vld) begin
            r_em_col <= r5_col;
            r_em_row <= r5_row;
            r_em_bgr <= r5_bgr;
        end
    end

    logic signed [23:0] pcol, prow;
    assign pcol = r_em_col + offx;
    assign prow = r_em_row + offy;

    assign o_px.valid           = (r_em_mask != '0);
    assign o_px.data.pixel_col  = pcol[11:0];
    assign o_px.data.pixel_row  = prow[11:0];
    assign o_px.data.pixel_bgr  = r_em_bgr;
    assign o_px.data.last_pixel = (rest == '0);

endmodule

// ----- hdl/pppd_chk.sv -----
// Port-level checker for pinhole_point_projector_dots, bound to the top level.
// Depends on the top level's port names only.
module pppd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_last,
    input logic [11:0] i_out_row
);

    // a pending pixel request holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("pixel request dropped while stalled");

    // reset empties the dot emitter
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("pixel request right after reset");

    // pixels of one dot follow back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside a dot");

    // row-major order within a dot
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_row >= $past(i_out_row))
        else $error("dot pixels out of row order");

endmodule

bind pinhole_point_projector_dots pppd_chk u_pppd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_px.valid),
    .i_out_ready (o_px.ready),
    .i_out_last  (o_px.data.last_pixel),
    .i_out_row   (o_px.data.pixel_row)
);
